// ----- design/tinted_sprite_mosaic_overlay_assert.svh -----
// Assertion macros of the tinted sprite mosaic overlay RTL, used by tsmo_blend.
// Clocked on clk; TSMO_ASSERT is disabled by arst_n; no other dependencies.
`ifndef TINTED_SPRITE_MOSAIC_OVERLAY_ASSERT_SVH
`define TINTED_SPRITE_MOSAIC_OVERLAY_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset
`define TSMO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every edge, reset included
`define TSMO_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSMO_ASSERT(lbl, prop, msg)
`define TSMO_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- design/tsmo_pkg.sv -----
// Shared types, codes and helpers of the tinted sprite mosaic overlay.
// No dependencies; imported by every module of the block.
package tsmo_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_TILE_SIZE    = 2'd2;

	// Register reset values
	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd550;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd500;
	localparam logic [6:0]  TILE_SIZE_RST    = 7'd7;

	// Line limit and counter widths
	localparam int MAX_LINES = 2048;
	localparam int LINE_W    = 11;
	localparam int HEIGHT_W  = 12;

	// Beat kind carried on tuser
	typedef enum logic {
		KIND_SPRITE = 1'b0,
		KIND_PIXEL  = 1'b1
	} kind_t;

	// Raster position flags of one pixel
	typedef struct packed {
		logic full_tile;   // pixel lies in a tile fully inside the frame
		logic tile_origin; // pixel is the top-left of its tile
		logic last_pixel;  // last pixel of the frame
	} pix_pos_t;

	// 8-bit add saturating at 255
	function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[8] ? 8'hFF : sum[7:0];
	endfunction

endpackage

// ----- design/tinted_sprite_mosaic_overlay.sv -----
// Top level of the tinted sprite mosaic overlay: ports, configuration registers.
// Depends on tsmo_pkg, tsmo_raster, tsmo_store and tsmo_blend.
//
//  channel   dir  handshake            contents
//  s_*       in   s_tvalid / s_tready  sprite texel write or image pixel
//  m_*       out  m_tvalid / m_tready  output pixel, tlast on frame end
//  cfg_*     in   cfg_we               frame_width, frame_height, tile_size
//
// One pixel or sprite write per cycle while s_tready is high; an accepted pixel sits
// in stage 1 (the stores' registered read port) and moves into the output register
// once that register is free or being drained, which raises m_tvalid.
// Stage 1 and the output register form a two-deep pipe; s_tready drops only
// while both hold pixels and m_tready is low.
// Reset clears counters and flags and loads the register defaults; the stores are
// not cleared and a sprite texel must be written before it is used.
module tinted_sprite_mosaic_overlay import tsmo_pkg::*; #(
	parameter int MAX_TILE  = 64,
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // sprite_addr[11:0], blue, green, red, alpha, zero pad
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_blue, out_green, out_red
	output logic        m_tlast,   // end_of_frame
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int AW = (MAX_TILE > 1) ? $clog2(MAX_TILE * MAX_TILE) : 1;

	logic [11:0] frame_width_q;
	logic [11:0] frame_height_q;
	logic [6:0]  tile_size_q;

	logic          accept;
	logic          pix_take;
	logic          sprite_we;
	logic [11:0]   in_addr;
	logic [23:0]   in_color;
	logic [7:0]    in_alpha;
	pix_pos_t      pos;
	logic [CW-1:0] tile_column;
	logic [AW-1:0] sprite_rd_addr;
	logic [31:0]   sprite_texel_s1;
	logic [23:0]   tile_color_s1;
	logic          ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			tile_size_q    <= TILE_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				CFG_TILE_SIZE:    tile_size_q    <= cfg_data[6:0];
				default:          ;
			endcase
		end
	end

	// Input beat decode
	assign in_addr   = s_tdata[11:0];
	assign in_color  = s_tdata[35:12];
	assign in_alpha  = s_tdata[43:36];
	assign s_tready  = ready;
	assign accept    = s_tvalid && ready;
	assign pix_take  = accept && (kind_t'(s_tuser) == KIND_PIXEL);
	assign sprite_we = accept && (kind_t'(s_tuser) == KIND_SPRITE) &&
	                   (32'(in_addr) < 32'(MAX_TILE * MAX_TILE));

	tsmo_raster #(
		.MAX_TILE  (MAX_TILE),
		.MAX_WIDTH (MAX_WIDTH)
	) u_raster (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (pix_take),
		.frame_width    (frame_width_q),
		.frame_height   (frame_height_q),
		.tile_size      (tile_size_q),
		.pos            (pos),
		.tile_column    (tile_column),
		.sprite_rd_addr (sprite_rd_addr)
	);

	tsmo_store #(
		.MAX_TILE  (MAX_TILE),
		.MAX_WIDTH (MAX_WIDTH)
	) u_store (
		.clk             (clk),
		.sprite_we       (sprite_we),
		.sprite_wr_addr  (AW'(in_addr)),
		.sprite_wr_data  ({in_alpha, in_color}),
		.pix_take        (pix_take),
		.tile_origin     (pos.tile_origin),
		.sprite_rd_addr  (sprite_rd_addr),
		.tile_column     (tile_column),
		.pix_color       (in_color),
		.sprite_texel_s1 (sprite_texel_s1),
		.tile_color_s1   (tile_color_s1)
	);

	tsmo_blend u_blend (
		.clk             (clk),
		.arst_n          (arst_n),
		.pix_take        (pix_take),
		.pix_color       (in_color),
		.pos             (pos),
		.sprite_texel_s1 (sprite_texel_s1),
		.tile_color_s1   (tile_color_s1),
		.ready           (ready),
		.m_tready        (m_tready),
		.m_tvalid        (m_tvalid),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast)
	);

endmodule

// ----- design/tsmo_raster.sv -----
// Raster and tile position counters of the tinted sprite mosaic overlay.
// Depends on tsmo_pkg; feeds tsmo_store addresses and tsmo_blend flags.
module tsmo_raster import tsmo_pkg::*; #(
	parameter int MAX_TILE  = 64,
	parameter int MAX_WIDTH = 2048,
	localparam int CW  = $clog2(MAX_WIDTH),
	localparam int TW  = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1,
	localparam int AW  = (MAX_TILE > 1) ? $clog2(MAX_TILE * MAX_TILE) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,          // pixel beat accepted
	input  logic [11:0]   frame_width,
	input  logic [11:0]   frame_height,
	input  logic [6:0]    tile_size,
	output pix_pos_t      pos,
	output logic [CW-1:0] tile_column,
	output logic [AW-1:0] sprite_rd_addr
);

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int WCMP = (WW > 12) ? WW : 12;
	localparam int PW   = TW + 1;
	localparam int TCMP = (PW > 7) ? PW : 7;
	localparam int XW   = ((CW > PW) ? CW : PW) + 1;
	localparam int YW   = ((LINE_W > PW) ? LINE_W : PW) + 1;

	logic [CW-1:0]     column_count_q;
	logic [LINE_W-1:0] line_count_q;
	logic [TW-1:0]     column_in_tile_q;
	logic [TW-1:0]     line_in_tile_q;
	logic [CW-1:0]     tile_column_q;

	logic [WCMP-1:0]     fw_x;
	logic [TCMP-1:0]     ts_x;
	logic [WW-1:0]       width_lim;
	logic [HEIGHT_W-1:0] height_lim;
	logic [PW-1:0]       ts_lim;
	logic [CW-1:0]       x0;
	logic [LINE_W-1:0]   y0;
	logic                col_wrap;
	logic                line_wrap;
	logic                cit_wrap;
	logic                lit_wrap;

	// Clamp the registers to their working ranges
	always_comb begin
		fw_x = WCMP'(frame_width);
		ts_x = TCMP'(tile_size);
		if (fw_x == '0)
			width_lim = WW'(1);
		else if (fw_x > WCMP'(MAX_WIDTH))
			width_lim = WW'(MAX_WIDTH);
		else
			width_lim = WW'(fw_x);
		if (frame_height == '0)
			height_lim = HEIGHT_W'(1);
		else if (frame_height > HEIGHT_W'(MAX_LINES))
			height_lim = HEIGHT_W'(MAX_LINES);
		else
			height_lim = frame_height;
		if (ts_x == '0)
			ts_lim = PW'(1);
		else if (ts_x > TCMP'(MAX_TILE))
			ts_lim = PW'(MAX_TILE);
		else
			ts_lim = PW'(ts_x);
	end

	// Tile tests and wrap conditions
	always_comb begin
		x0 = column_count_q - CW'(column_in_tile_q);
		y0 = line_count_q - LINE_W'(line_in_tile_q);
		pos.full_tile = (XW'(x0) + XW'(ts_lim) <= XW'(width_lim)) &&
		                (YW'(y0) + YW'(ts_lim) <= YW'(height_lim));
		pos.tile_origin = (line_in_tile_q == '0) && (column_in_tile_q == '0);
		col_wrap  = ((CW + 1)'(column_count_q) + (CW + 1)'(1)) >= (CW + 1)'(width_lim);
		line_wrap = (HEIGHT_W'(line_count_q) + HEIGHT_W'(1)) >= height_lim;
		cit_wrap  = (PW'(column_in_tile_q) + PW'(1)) >= ts_lim;
		lit_wrap  = (PW'(line_in_tile_q) + PW'(1)) >= ts_lim;
		pos.last_pixel = col_wrap && line_wrap;
	end

	// Store addresses for the current pixel
	assign tile_column    = tile_column_q;
	assign sprite_rd_addr = AW'(AW'(line_in_tile_q) * AW'(MAX_TILE) + AW'(column_in_tile_q));

	// Advance the raster position on each pixel beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q   <= '0;
			line_count_q     <= '0;
			column_in_tile_q <= '0;
			line_in_tile_q   <= '0;
			tile_column_q    <= '0;
		end else if (step) begin
			if (col_wrap) begin
				column_count_q   <= '0;
				column_in_tile_q <= '0;
				tile_column_q    <= '0;
				if (line_wrap) begin
					line_count_q   <= '0;
					line_in_tile_q <= '0;
				end else begin
					line_count_q   <= line_count_q + LINE_W'(1);
					line_in_tile_q <= lit_wrap ? '0 : line_in_tile_q + TW'(1);
				end
			end else begin
				column_count_q <= column_count_q + CW'(1);
				if (cit_wrap) begin
					column_in_tile_q <= '0;
					tile_column_q    <= tile_column_q + CW'(1);
				end else begin
					column_in_tile_q <= column_in_tile_q + TW'(1);
				end
			end
		end
	end

endmodule

// ----- design/tsmo_store.sv -----
// Sprite texel memory and per-tile top-left color memory.
// Depends on tsmo_pkg; read data is registered into stage 1 for tsmo_blend.
module tsmo_store import tsmo_pkg::*; #(
	parameter int MAX_TILE  = 64,
	parameter int MAX_WIDTH = 2048,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int AW = (MAX_TILE > 1) ? $clog2(MAX_TILE * MAX_TILE) : 1
) (
	input  logic          clk,
	input  logic          sprite_we,
	input  logic [AW-1:0] sprite_wr_addr,
	input  logic [31:0]   sprite_wr_data,   // alpha, red, green, blue from the top
	input  logic          pix_take,
	input  logic          tile_origin,
	input  logic [AW-1:0] sprite_rd_addr,
	input  logic [CW-1:0] tile_column,
	input  logic [23:0]   pix_color,        // red, green, blue from the top
	output logic [31:0]   sprite_texel_s1,
	output logic [23:0]   tile_color_s1
);

	localparam int SPRITE_DEPTH = MAX_TILE * MAX_TILE;

	logic [31:0] sprite_mem [SPRITE_DEPTH];
	logic [23:0] tile_mem   [MAX_WIDTH];

	// Sprite texels: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (sprite_we)
			sprite_mem[sprite_wr_addr] <= sprite_wr_data;
		if (pix_take)
			sprite_texel_s1 <= sprite_mem[sprite_rd_addr];
	end

	// Tile colors: written at each tile's top-left pixel, read before write
	always_ff @(posedge clk) begin
		if (pix_take && tile_origin)
			tile_mem[tile_column] <= pix_color;
		if (pix_take)
			tile_color_s1 <= tile_mem[tile_column];
	end

endmodule

// ----- design/tsmo_blend.sv -----
// Stage-1 pixel register, tint blend and output register of the overlay.
// Depends on tsmo_pkg and the assertion header; texel and tile color from tsmo_store.
`include "tinted_sprite_mosaic_overlay_assert.svh"

module tsmo_blend import tsmo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_take,
	input  logic [23:0] pix_color,
	input  pix_pos_t    pos,
	input  logic [31:0] sprite_texel_s1,
	input  logic [23:0] tile_color_s1,
	output logic        ready,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [23:0] m_tdata,
	output logic        m_tlast
);

	logic        s1_valid_s1;
	logic [23:0] color_s1;
	pix_pos_t    pos_s1;
	logic        m_valid_q;
	logic [23:0] m_data_q;
	logic        m_last_q;

	logic        s1_adv;
	logic [23:0] tint;
	logic        draw;
	logic [23:0] blended;

	// Stage 1 moves when the output register is free or being drained
	assign s1_adv = s1_valid_s1 && (!m_valid_q || m_tready);
	assign ready  = !s1_valid_s1 || s1_adv;

	// Own color stands in for the tile color at the tile's top-left pixel
	always_comb begin
		tint = pos_s1.tile_origin ? color_s1 : tile_color_s1;
		draw = pos_s1.full_tile && (sprite_texel_s1[31:24] != 8'd0);
		blended = color_s1;
		if (draw) begin
			blended[7:0]   = sat_add8(sprite_texel_s1[7:0],   tint[7:0]);
			blended[15:8]  = sat_add8(sprite_texel_s1[15:8],  tint[15:8]);
			blended[23:16] = sat_add8(sprite_texel_s1[23:16], tint[23:16]);
		end
	end

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (pix_take)
				s1_valid_s1 <= 1'b1;
			else if (s1_adv)
				s1_valid_s1 <= 1'b0;
			if (s1_adv)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pix_take) begin
			color_s1 <= pix_color;
			pos_s1   <= pos;
		end
		if (s1_adv) begin
			m_data_q <= blended;
			m_last_q <= pos_s1.last_pixel;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	`TSMO_ASSERT(a_s1_holds, s1_valid_s1 && !s1_adv |=> s1_valid_s1 && $stable(color_s1), "stage 1 lost a stalled pixel")
	`TSMO_ASSERT(a_take_fills, pix_take |=> s1_valid_s1, "accepted pixel did not reach stage 1")
	`TSMO_ASSERT(a_out_source, $rose(m_valid_q) |-> $past(s1_valid_s1), "output beat without a stage 1 pixel")
	`TSMO_ASSERT_ALWAYS(a_empty_ready, !s1_valid_s1 |-> ready, "empty stage 1 not ready")

endmodule
